// ----- hw/rtl/wcs_pkg.sv -----
package wcs_pkg;

  localparam int TUPLE_SLOTS  = 8;
  localparam int ELEMENT_BITS = 16;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 4;
  localparam int FIELD_W = 16;
  localparam int LEN_W   = 4;

  localparam int IDX_W  = (TUPLE_SLOTS > 1) ? $clog2(TUPLE_SLOTS) : 1;
  localparam int CNT_W  = ($clog2(TUPLE_SLOTS + 1) > INDEX_W) ? $clog2(TUPLE_SLOTS + 1)
                                                              : INDEX_W;
  localparam int WIDE_W = (ELEMENT_BITS > FIELD_W) ? ELEMENT_BITS : FIELD_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

  typedef logic [ELEMENT_BITS-1:0] elem_t;
  typedef logic [IDX_W-1:0]        slot_idx_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_STEP     = 2'd2,
    CMD_SATURATE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_UPDATE,
    ST_FOLD,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    STEP_SHIFT,
    STEP_SINGLE,
    STEP_GRADE
  } step_case_t;

endpackage

// ----- hw/rtl/wcs_cmd_if.sv -----
interface wcs_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [wcs_pkg::CMD_W-1:0]   command;
  logic [wcs_pkg::INDEX_W-1:0] index;
  logic [wcs_pkg::FIELD_W-1:0] value;

  modport source(output valid, command, index, value, input ready);
  modport sink(input valid, command, index, value, output ready);
endinterface

// ----- hw/rtl/wcs_res_if.sv -----
interface wcs_res_if;
  logic                        valid;
  logic                        ready;
  logic [wcs_pkg::FIELD_W-1:0] read_value;
  logic                        overflow;

  modport source(output valid, read_value, overflow, input ready);
  modport sink(input valid, read_value, overflow, output ready);
endinterface

// ----- hw/rtl/wcs_sat_add.sv -----
module wcs_sat_add (
  input  wcs_pkg::elem_t a,
  input  wcs_pkg::elem_t b,
  output wcs_pkg::elem_t sum,
  output wcs_pkg::elem_t sat_sum,
  output logic           carry
);

  logic [wcs_pkg::ELEMENT_BITS:0] full;

  assign full    = {1'b0, a} + {1'b0, b};
  assign sum     = full[wcs_pkg::ELEMENT_BITS-1:0];
  assign carry   = full[wcs_pkg::ELEMENT_BITS];
  assign sat_sum = carry ? '1 : full[wcs_pkg::ELEMENT_BITS-1:0];

endmodule

// ----- hw/rtl/weak_composition_stepper.sv -----
// Weak composition stepper: holds up to TUPLE_SLOTS entries and, on a step command, moves the
// tuple to the next weak composition in graded order; saturate folds the tail into position m,
// write and read access single entries, and every command returns one result item. One item
// at a time is in work: a new command is taken only after the last has loaded its result. Write
// and read access one entry, a step scans the n used entries and updates, and a saturate scans
// and folds (with m at or past n, it skips both). The pace is set by the entries' single read port,
// scanned one entry a cycle, and one shared saturating adder for the scan and update writes.
module weak_composition_stepper (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [wcs_pkg::LEN_W-1:0] cfg_wdata,
  wcs_cmd_if.sink                   cmd,
  wcs_res_if.source                 res
);

  wcs_pkg::state_t   state, state_next;
  wcs_pkg::cmd_t     op;
  wcs_pkg::cmd_t     cmd_in;
  logic [wcs_pkg::LEN_W-1:0] tuple_length;

  wcs_pkg::elem_t    entries [wcs_pkg::TUPLE_SLOTS];
  wcs_pkg::elem_t    rdata;

  wcs_pkg::count_t    n_use, n_in, len_ext, idx_ext;
  wcs_pkg::slot_idx_t ptr, last_idx, m_idx, t_idx;
  logic               in_range;
  wcs_pkg::elem_t     wval, e0, elast, vt, vtm1, prev, acc;
  logic               found, multi, pre_nz;
  logic [1:0]         k;
  logic [wcs_pkg::FIELD_W-1:0] rd_acc, res_rd;
  logic               ovf_acc, res_ovf, res_valid;

  logic [wcs_pkg::WIDE_W-1:0] val_wide;
  logic               wsat;
  wcs_pkg::elem_t     wval_in;

  logic               wr_en;
  wcs_pkg::slot_idx_t wr_addr;
  wcs_pkg::elem_t     wr_data;
  wcs_pkg::elem_t     add_a, add_b, add_sum, add_sat;
  logic               add_carry, set_ovf, load_res, accept, nz;
  wcs_pkg::step_case_t step_case;
  wcs_pkg::elem_t     fold_val;

  wcs_sat_add u_add (
    .a       (add_a),
    .b       (add_b),
    .sum     (add_sum),
    .sat_sum (add_sat),
    .carry   (add_carry)
  );

  assign cmd_in   = wcs_pkg::cmd_t'(cmd.command);
  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == wcs_pkg::ST_IDLE);
  assign rdata    = entries[ptr];
  assign nz       = (rdata != '0);

  assign len_ext = wcs_pkg::CNT_W'(tuple_length);
  assign idx_ext = wcs_pkg::CNT_W'(cmd.index);
  always_comb begin
    if (len_ext == '0) begin
      n_in = wcs_pkg::CNT_W'(1);
    end else if (len_ext > wcs_pkg::CNT_W'(wcs_pkg::TUPLE_SLOTS)) begin
      n_in = wcs_pkg::CNT_W'(wcs_pkg::TUPLE_SLOTS);
    end else begin
      n_in = len_ext;
    end
  end

  assign val_wide = wcs_pkg::WIDE_W'(cmd.value);
  assign wsat     = val_wide > wcs_pkg::WIDE_W'({wcs_pkg::ELEMENT_BITS{1'b1}});
  assign wval_in  = wsat ? '1 : wcs_pkg::ELEMENT_BITS'(val_wide);

  always_comb begin
    if (found && (t_idx != '0)) begin
      step_case = multi ? wcs_pkg::STEP_SHIFT : wcs_pkg::STEP_SINGLE;
    end else begin
      step_case = wcs_pkg::STEP_GRADE;
    end
  end

  assign fold_val = ((acc == '0) && !pre_nz) ? wcs_pkg::ELEMENT_BITS'(1) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = ptr;
    wr_data    = '0;
    add_a      = acc;
    add_b      = rdata;
    set_ovf    = 1'b0;
    load_res   = 1'b0;
    case (state)
      wcs_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd_in)
            wcs_pkg::CMD_STEP:     state_next = wcs_pkg::ST_SCAN;
            wcs_pkg::CMD_SATURATE: state_next = (idx_ext < n_in) ? wcs_pkg::ST_SCAN
                                                                 : wcs_pkg::ST_FINISH;
            default:               state_next = wcs_pkg::ST_ACCESS;
          endcase
        end
      end
      wcs_pkg::ST_ACCESS: begin
        if ((op == wcs_pkg::CMD_WRITE) && in_range) begin
          wr_en   = 1'b1;
          wr_data = wval;
        end
        state_next = wcs_pkg::ST_FINISH;
      end
      wcs_pkg::ST_SCAN: begin
        if ((op == wcs_pkg::CMD_SATURATE) && (ptr > m_idx)) begin
          wr_en   = 1'b1;
          set_ovf = add_carry;
        end
        if (ptr == last_idx) begin
          state_next = (op == wcs_pkg::CMD_STEP) ? wcs_pkg::ST_UPDATE : wcs_pkg::ST_FOLD;
        end
      end
      wcs_pkg::ST_UPDATE: begin
        wr_en = 1'b1;
        case (step_case)
          wcs_pkg::STEP_SHIFT: begin
            case (k)
              2'd0: begin
                wr_addr = t_idx;
                wr_data = elast;
              end
              2'd1: begin
                add_a   = vt;
                add_b   = '1;
                wr_addr = last_idx;
                wr_data = add_sum;
              end
              default: begin
                add_a   = vtm1;
                add_b   = wcs_pkg::ELEMENT_BITS'(1);
                wr_addr = wcs_pkg::IDX_W'(t_idx - 1'b1);
                wr_data = add_sat;
                set_ovf = add_carry;
              end
            endcase
          end
          wcs_pkg::STEP_SINGLE: begin
            case (k)
              2'd0: begin
                wr_addr = wcs_pkg::IDX_W'(t_idx - 1'b1);
                wr_data = wcs_pkg::ELEMENT_BITS'(1);
              end
              2'd1: begin
                wr_addr = t_idx;
                wr_data = '0;
              end
              default: begin
                add_a   = vt;
                add_b   = '1;
                wr_addr = last_idx;
                wr_data = add_sum;
              end
            endcase
          end
          default: begin
            case (k)
              2'd0: begin
                wr_addr = '0;
                wr_data = '0;
              end
              2'd1: begin
                add_a   = e0;
                add_b   = wcs_pkg::ELEMENT_BITS'(1);
                wr_addr = last_idx;
                wr_data = add_sat;
                set_ovf = add_carry;
              end
              default: wr_en = 1'b0;
            endcase
          end
        endcase
        if (k == 2'd2) begin
          state_next = wcs_pkg::ST_FINISH;
        end
      end
      wcs_pkg::ST_FOLD: begin
        wr_en      = 1'b1;
        wr_addr    = m_idx;
        wr_data    = fold_val;
        state_next = wcs_pkg::ST_FINISH;
      end
      wcs_pkg::ST_FINISH: begin
        if (!res_valid || res.ready) begin
          load_res   = 1'b1;
          state_next = wcs_pkg::ST_IDLE;
        end
      end
      default: state_next = wcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tuple_length <= wcs_pkg::LEN_RESET;
    end else if (cfg_we) begin
      tuple_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '{default: '0};
    end else if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= cmd_in;
      n_use    <= n_in;
      last_idx <= wcs_pkg::IDX_W'(n_in - 1'b1);
      in_range <= idx_ext < n_in;
      m_idx    <= idx_ext[wcs_pkg::IDX_W-1:0];
      ptr      <= ((cmd_in == wcs_pkg::CMD_WRITE) || (cmd_in == wcs_pkg::CMD_READ))
                  ? idx_ext[wcs_pkg::IDX_W-1:0] : '0;
      wval     <= wval_in;
      ovf_acc  <= (cmd_in == wcs_pkg::CMD_WRITE) && (idx_ext < n_in) && wsat;
      rd_acc   <= '0;
      found    <= 1'b0;
      multi    <= 1'b0;
      pre_nz   <= 1'b0;
      k        <= '0;
    end else begin
      case (state)
        wcs_pkg::ST_ACCESS: begin
          if ((op == wcs_pkg::CMD_READ) && in_range) begin
            rd_acc <= wcs_pkg::FIELD_W'(rdata);
          end
        end
        wcs_pkg::ST_SCAN: begin
          ptr  <= wcs_pkg::IDX_W'(ptr + 1'b1);
          prev <= rdata;
          if (ptr == '0) begin
            e0 <= rdata;
          end
          if (ptr == last_idx) begin
            elast <= rdata;
          end
          if (nz) begin
            found <= 1'b1;
            t_idx <= ptr;
            vt    <= rdata;
            vtm1  <= prev;
            if (found) begin
              multi <= 1'b1;
            end
          end
          if (ptr < m_idx) begin
            pre_nz <= pre_nz | nz;
          end else if (ptr == m_idx) begin
            acc <= rdata;
          end else begin
            acc <= add_sat;
          end
          if (set_ovf) begin
            ovf_acc <= 1'b1;
          end
        end
        wcs_pkg::ST_UPDATE: begin
          k <= k + 2'd1;
          if (set_ovf) begin
            ovf_acc <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_rd  <= rd_acc;
      res_ovf <= ovf_acc;
    end
  end

  assign res.valid      = res_valid;
  assign res.read_value = res_rd;
  assign res.overflow   = res_ovf;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("input taken again while an item is in work");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == wcs_pkg::ST_SCAN) |-> (wcs_pkg::CNT_W'(ptr) < n_use))
    else $error("scan pointer past used length");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wcs_pkg::CNT_W'(wr_addr) < n_use))
    else $error("entry write past used length");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import wcs_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [WIDE_W-1:0] ELEM_TOP = WIDE_W'({ELEMENT_BITS{1'b1}});

  typedef struct packed {
    logic [FIELD_W-1:0] read_value;
    logic               overflow;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  wcs_cmd_if cmd_if ();
  wcs_res_if res_if ();

  weak_composition_stepper dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_wdata,
    .cmd(cmd_if),
    .res(res_if)
  );

  elem_t            tuple_model [TUPLE_SLOTS];
  logic [LEN_W-1:0] length_model;
  outcome_t         pending_outcomes [$];
  outcome_t         want;
  int               errors;
  int               stall_left;
  int               quiet_cycles;
  bit               send_idle;
  bit               take_idle;

  always #5 clk = ~clk;

  function automatic int active_length();
    int n;
    n = length_model;
    if (n == 0) n = 1;
    if (n > TUPLE_SLOTS) n = TUPLE_SLOTS;
    return n;
  endfunction

  function automatic elem_t sat_sum(elem_t a, elem_t b, inout logic ovf);
    logic [ELEMENT_BITS:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    if (wide[ELEMENT_BITS]) begin
      ovf = 1'b1;
      return '1;
    end
    return wide[ELEMENT_BITS-1:0];
  endfunction

  function automatic outcome_t apply_command(cmd_t op, logic [INDEX_W-1:0] idx,
                                             logic [FIELD_W-1:0] val);
    int       n;
    int       last;
    int       pos;
    logic     lone;
    logic     prefix_zero;
    logic     ovf;
    elem_t    moved;
    outcome_t out;
    n = active_length();
    out = '0;
    ovf = 1'b0;
    case (op)
      CMD_WRITE: begin
        if (idx < n) begin
          if (WIDE_W'(val) > ELEM_TOP) begin
            ovf = 1'b1;
            tuple_model[idx] = '1;
          end else begin
            tuple_model[idx] = elem_t'(val);
          end
        end
      end
      CMD_READ: begin
        if (idx < n) out.read_value = FIELD_W'(tuple_model[idx]);
      end
      CMD_STEP: begin
        last = n - 1;
        while (last >= 0 && tuple_model[last] == '0) last--;
        lone = 1'b1;
        for (pos = 0; pos < last; pos++)
          if (tuple_model[pos] != '0) lone = 1'b0;
        if (last > 0 && !lone) begin
          moved = tuple_model[last];
          tuple_model[last] = tuple_model[n-1];
          tuple_model[n-1] = moved - 1'b1;
          tuple_model[last-1] = sat_sum(tuple_model[last-1], elem_t'(1), ovf);
        end else if (last > 0) begin
          moved = tuple_model[last];
          tuple_model[last-1] = elem_t'(1);
          tuple_model[last] = '0;
          tuple_model[n-1] = moved - 1'b1;
        end else begin
          moved = tuple_model[0];
          tuple_model[n-1] = sat_sum(moved, elem_t'(1), ovf);
          if (n > 1) tuple_model[0] = '0;
        end
      end
      CMD_SATURATE: begin
        if (idx < n) begin
          for (pos = int'(idx) + 1; pos < n; pos++) begin
            tuple_model[idx] = sat_sum(tuple_model[idx], tuple_model[pos], ovf);
            tuple_model[pos] = '0;
          end
          if (tuple_model[idx] == '0) begin
            prefix_zero = 1'b1;
            for (pos = 0; pos < int'(idx); pos++)
              if (tuple_model[pos] != '0) prefix_zero = 1'b0;
            if (prefix_zero) tuple_model[idx] = elem_t'(1);
          end
        end
      end
      default: ;
    endcase
    out.overflow = ovf;
    return out;
  endfunction

  task automatic send_item(cmd_t op, logic [INDEX_W-1:0] idx, logic [FIELD_W-1:0] val);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.index   <= idx;
    cmd_if.value   <= val;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pending_outcomes.push_back(apply_command(op, idx, val));
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_model = len;
  endtask

  function automatic logic [FIELD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return FIELD_W'($urandom_range(0, 3));
    if (r == 6) return '0;
    if (r == 7) return FIELD_W'(ELEM_TOP) - FIELD_W'($urandom_range(0, 2));
    return FIELD_W'($urandom);
  endfunction

  task automatic run_round(int count);
    int n;
    int k;
    int w;
    n = active_length();
    for (k = 0; k < n; k++)
      if ($urandom_range(0, 1) == 0) send_item(CMD_WRITE, INDEX_W'(k), pick_value());
    for (k = 0; k < count; k++) begin
      w = $urandom_range(0, 9);
      if (w < 6) begin
        send_item(CMD_STEP, INDEX_W'($urandom), FIELD_W'($urandom));
      end else if (w < 8) begin
        send_item(CMD_READ, INDEX_W'($urandom_range(0, n - 1)), FIELD_W'($urandom));
      end else if (w == 8) begin
        if ($urandom_range(0, 3) != 0)
          send_item(CMD_SATURATE, INDEX_W'($urandom_range(0, n - 1)), FIELD_W'($urandom));
        else
          send_item(CMD_SATURATE, INDEX_W'($urandom_range(0, 15)), FIELD_W'($urandom));
      end else begin
        send_item(cmd_t'($urandom_range(0, 3)), INDEX_W'($urandom_range(0, 15)),
                  FIELD_W'($urandom));
      end
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    if ($urandom_range(0, 9) < 6) return LEN_W'($urandom_range(1, 5));
    return LEN_W'($urandom_range(0, 15));
  endfunction

  task automatic test_reset_values();
    send_item(CMD_READ, INDEX_W'(0), '0);
    send_item(CMD_READ, INDEX_W'(7), '1);
    send_item(CMD_READ, INDEX_W'(15), '0);
  endtask

  task automatic test_step_cases();
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '1, '1);
    send_item(CMD_WRITE, INDEX_W'(0), FIELD_W'(3));
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_WRITE, INDEX_W'(4), FIELD_W'(ELEM_TOP));
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_READ, INDEX_W'(4), '0);
  endtask

  task automatic test_saturate_cases();
    send_item(CMD_WRITE, INDEX_W'(2), FIELD_W'(ELEM_TOP));
    send_item(CMD_WRITE, INDEX_W'(6), FIELD_W'(1));
    send_item(CMD_SATURATE, INDEX_W'(2), '0);
    send_item(CMD_SATURATE, INDEX_W'(15), '0);
    send_item(CMD_SATURATE, INDEX_W'(8), '0);
    send_item(CMD_WRITE, INDEX_W'(0), '0);
    send_item(CMD_WRITE, INDEX_W'(2), '0);
    send_item(CMD_SATURATE, INDEX_W'(3), '0);
    send_item(CMD_WRITE, INDEX_W'(15), '1);
    send_item(CMD_READ, INDEX_W'(3), '0);
  endtask

  task automatic test_length_limits();
    set_length(LEN_W'(0));
    send_item(CMD_WRITE, INDEX_W'(0), FIELD_W'(ELEM_TOP));
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_READ, INDEX_W'(1), '0);
    set_length(LEN_W'(15));
    send_item(CMD_READ, INDEX_W'(7), '0);
    send_item(CMD_STEP, '0, '0);
    set_length(LEN_W'(1));
    send_item(CMD_STEP, '0, '0);
    set_length(LEN_W'(8));
  endtask

  task automatic test_random_walk();
    int sent;
    int count;
    sent = 0;
    while (sent < 1050) begin
      set_length(pick_length());
      send_idle = ($urandom_range(0, 3) != 0);
      take_idle = ($urandom_range(0, 3) != 0);
      count = $urandom_range(15, 40);
      run_round(count);
      sent += count;
    end
  endtask

  task automatic test_quiet_channels();
    int sent;
    int count;
    drain_results();
    send_idle = 1'b0;
    take_idle = 1'b0;
    sent = 0;
    while (sent < 150) begin
      set_length(pick_length());
      count = $urandom_range(20, 40);
      run_round(count);
      sent += count;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t unexpected result item: read_value %h overflow %b", $time,
                   res_if.read_value, res_if.overflow);
        end else begin
          want = pending_outcomes.pop_front();
          if (res_if.read_value !== want.read_value) begin
            errors++;
            $display("%0t read_value mismatch: expected %h actual %h", $time,
                     want.read_value, res_if.read_value);
          end
          if (res_if.overflow !== want.overflow) begin
            errors++;
            $display("%0t overflow mismatch: expected %b actual %b", $time,
                     want.overflow, res_if.overflow);
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (take_idle && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 5);
      res_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_WRITE;
    cmd_if.index   = '0;
    cmd_if.value   = '0;
    send_idle      = 1'b1;
    take_idle      = 1'b1;
    for (int i = 0; i < TUPLE_SLOTS; i++) tuple_model[i] = '0;
    length_model = LEN_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_step_cases();
    test_saturate_cases();
    test_length_limits();
    test_random_walk();
    test_quiet_channels();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- weak_composition_stepper.f -----
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_cmd_if.sv
hw/rtl/wcs_res_if.sv
hw/rtl/wcs_sat_add.sv
hw/rtl/weak_composition_stepper.sv
tb/tb_top.sv
